/* design/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable sorted priority queue
// Entry, request and response layouts, request and status codes, and the
// queue depth.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH  = 64;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int TAG_W  = 16;
	localparam int PRIO_W = 4;
	localparam int FILL_W = 7;
	localparam int STAT_W = 2;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic              req_type;
		logic [PRIO_W-1:0] priority_req;
		logic [TAG_W-1:0]  tag;
	} req_t;

	typedef struct packed {
		logic [TAG_W-1:0]  out_tag;
		logic [PRIO_W-1:0] out_priority;
		logic [STAT_W-1:0] status;
		logic [FILL_W-1:0] fill_level;
	} rsp_t;

	typedef struct packed {
		logic enq;      // insert the new entry this cycle
		logic deq;      // drop the front entry this cycle
		logic occ;      // this cell holds an entry
		logic at_free;  // this cell is the first free one
	} cell_ctl_t;

endpackage

/* design/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell: one storage cell of the shift-register priority queue
// Holds one entry, compares it with the incoming priority and takes its
// new value from the left neighbor, the right neighbor or the new entry.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    left_entry,
	input  logic               left_gt,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               gt
);
	import spq_pkg::*;

	entry_t entry_q;

	// Strictly greater priority moves back; equal stays ahead of the newcomer.
	assign gt    = ctl.occ && (new_entry.prio < entry_q.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.enq && (gt || ctl.at_free)) begin
			if (left_gt) begin
				entry_q <= left_entry;
			end else begin
				entry_q <= new_entry;
			end
		end else if (ctl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* design/stable_sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: shift-register priority queue of tagged entries
// Response: registered; an accepted request's response transaction follows in the next cycle.
// Throughput: one request per cycle while the response is not stalled; every cell compares and shifts at once.
// Reset: arst_n clears the fill count and the response valid; cell contents
//        are not reset and are only read below the fill count.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	entry_t    cell_entry [DEPTH];
	logic      cell_gt    [DEPTH];
	cell_ctl_t cell_ctl   [DEPTH];
	entry_t    new_entry;

	logic accept;
	logic full;
	logic empty;
	logic enq_ok;
	logic deq_ok;
	rsp_t rsp_next;

	// Take a new request whenever the response register is free or drains now.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign enq_ok = accept && (req.req_type == REQ_ENQ) && !full;
	assign deq_ok = accept && (req.req_type == REQ_DEQ) && !empty;

	assign new_entry.tag  = req.tag;
	assign new_entry.prio = req.priority_req;

	// Chain of cells: cell 0 is the front. On enqueue the greater-priority tail
	// moves one cell back and the newcomer drops into the gap; on dequeue
	// every cell takes its right neighbor's entry.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_ctl[i].enq     = enq_ok;
		assign cell_ctl[i].deq     = deq_ok;
		assign cell_ctl[i].occ     = (CNT_W'(i) < count_q);
		assign cell_ctl[i].at_free = (CNT_W'(i) == count_q);

		if (i == 0) begin : g_front
			spq_cell u_cell (
				.clk         (clk),
				.ctl         (cell_ctl[i]),
				.new_entry   (new_entry),
				.left_entry  (new_entry),
				.left_gt     (1'b0),
				.right_entry (cell_entry[i+1]),
				.entry       (cell_entry[i]),
				.gt          (cell_gt[i])
			);
		end else if (i == DEPTH - 1) begin : g_back
			spq_cell u_cell (
				.clk         (clk),
				.ctl         (cell_ctl[i]),
				.new_entry   (new_entry),
				.left_entry  (cell_entry[i-1]),
				.left_gt     (cell_gt[i-1]),
				.right_entry (cell_entry[i]),
				.entry       (cell_entry[i]),
				.gt          (cell_gt[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk         (clk),
				.ctl         (cell_ctl[i]),
				.new_entry   (new_entry),
				.left_entry  (cell_entry[i-1]),
				.left_gt     (cell_gt[i-1]),
				.right_entry (cell_entry[i+1]),
				.entry       (cell_entry[i]),
				.gt          (cell_gt[i])
			);
		end
	end

	// Build the response; dropped and failed requests report zero payload.
	always_comb begin
		rsp_next = '0;
		if (req.req_type == REQ_ENQ) begin
			if (full) begin
				rsp_next.status     = ST_FULL;
				rsp_next.fill_level = FILL_W'(count_q);
			end else begin
				rsp_next.status     = ST_OK;
				rsp_next.fill_level = FILL_W'(count_q + CNT_W'(1));
			end
		end else begin
			if (empty) begin
				rsp_next.status = ST_EMPTY;
			end else begin
				rsp_next.out_tag      = cell_entry[0].tag;
				rsp_next.out_priority = cell_entry[0].prio;
				rsp_next.status       = ST_OK;
				rsp_next.fill_level   = FILL_W'(count_q - CNT_W'(1));
			end
		end
	end

	// Advance the fill count and hold the response until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (enq_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (deq_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* design/spq_chk.sv */
// ----------------------------------------------------------------------------
// spq_chk: port-level checks of the stable sorted priority queue
// Watches the request and response transactions on the top level's ports.
// ----------------------------------------------------------------------------
module spq_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input spq_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response transaction changed");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted request produced no response");

	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |->
			(rsp.fill_level == FILL_W'(DEPTH)) && (rsp.out_tag == '0))
		else $error("full response with wrong level or payload");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY) |->
			(rsp.fill_level == '0) && (rsp.out_tag == '0) && (rsp.out_priority == '0))
		else $error("empty response with nonzero fields");

endmodule

bind stable_sorted_priority_queue spq_chk u_spq_chk (.*);
